// File: sv/sslod_pkg.sv
// Shared widths, register codes and helpers for the screen-space LOD select unit.
`timescale 1ns / 1ps
package sslod_pkg;

  localparam int CORNER_COUNT = 8;
  localparam int AXES         = 3;
  localparam int ROWS         = 3;   // clip x, clip y and clip w rows

  localparam int IN_W    = 24;
  localparam int COORD_W = 25;
  localparam int COEF_W  = 16;
  localparam int PROD_W  = 41;
  localparam int CLIP_W  = 43;
  localparam int MAG_W   = 59;       // |clip| * 65536
  localparam int REM_W   = 44;
  localparam int NDC_W   = 60;
  localparam int SPAN_W  = 41;
  localparam int SCR_W   = 14;
  localparam int HALF_W  = 16;
  localparam int PIX_W   = 55;
  localparam int OUT_W   = 16;
  localparam int ROW_W   = 64;
  localparam int ADDR_W  = 6;

  localparam logic [SPAN_W-1:0] SPAN_CAP   = SPAN_W'(1) << 40;
  localparam logic [PIX_W-1:0]  LOD0_LIMIT = PIX_W'(80) << 17;
  localparam logic [PIX_W-1:0]  LOD1_LIMIT = PIX_W'(30) << 17;
  localparam logic [OUT_W-1:0]  PIX_MAX    = '1;

  localparam logic [1:0] LOD_FULL   = 2'd0;
  localparam logic [1:0] LOD_MEDIUM = 2'd1;
  localparam logic [1:0] LOD_LOW    = 2'd2;

  typedef enum logic [2:0] {
    REG_ROW0   = 3'd0,
    REG_ROW1   = 3'd1,
    REG_ROW2   = 3'd2,
    REG_ROW3   = 3'd3,
    REG_WIDTH  = 3'd4,
    REG_HEIGHT = 3'd5,
    REG_HALF   = 3'd6
  } cfg_reg_e;

  function automatic logic signed [COEF_W-1:0] lane_coef(logic [ROW_W-1:0] row, int lane);
    return row[COEF_W*lane +: COEF_W];
  endfunction

  function automatic logic [CLIP_W-1:0] clip_abs(logic signed [CLIP_W-1:0] v);
    logic signed [CLIP_W-1:0] n;
    n = -v;
    return v[CLIP_W-1] ? CLIP_W'(n) : CLIP_W'(v);
  endfunction

endpackage

// File: sv/sslod_corner.sv
// Corner formation and clip-space transform, ending in division operands.
`timescale 1ns / 1ps
module sslod_corner
  import sslod_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic signed [IN_W-1:0]   center_x_i,
  input  logic signed [IN_W-1:0]   center_y_i,
  input  logic signed [IN_W-1:0]   center_z_i,
  input  logic [ROW_W-1:0]         matrix_i [4],
  input  logic [HALF_W-1:0]        half_i,
  output logic                     valid_o,
  output logic                     wz_o,
  output logic [MAG_W-1:0]         num_o [CORNER_COUNT][2],
  output logic [CLIP_W-1:0]        den_o [CORNER_COUNT],
  output logic                     neg_o [CORNER_COUNT][2]
);

  logic signed [COORD_W-1:0] coord_q [AXES][2];
  logic signed [PROD_W-1:0]  prod_q  [ROWS][AXES][2];
  logic signed [CLIP_W-1:0]  bias_q  [ROWS];
  logic signed [CLIP_W-1:0]  clip_q  [CORNER_COUNT][ROWS];
  logic [2:0] vld_q;

  logic signed [COORD_W-1:0] cen [AXES];
  logic signed [COORD_W-1:0] half_s;
  logic                      wz_d;

  assign cen[0] = COORD_W'(center_x_i);
  assign cen[1] = COORD_W'(center_y_i);
  assign cen[2] = COORD_W'(center_z_i);
  assign half_s = COORD_W'(half_i);

  always_comb begin
    wz_d = 1'b0;
    for (int i = 0; i < CORNER_COUNT; i++) begin
      if (clip_q[i][2] == '0) wz_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      vld_q   <= {vld_q[1:0], valid_i};
      valid_o <= vld_q[2];
    end
  end

  // Clip values are linear in each coordinate, so every row needs only the
  // low and high product per axis; corners pick among them.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int a = 0; a < AXES; a++) begin
        coord_q[a][0] <= cen[a] - half_s;
        coord_q[a][1] <= cen[a] + half_s;
      end
      for (int r = 0; r < ROWS; r++) begin
        for (int a = 0; a < AXES; a++) begin
          for (int s = 0; s < 2; s++) begin
            prod_q[r][a][s] <= PROD_W'(lane_coef(matrix_i[(r == 2) ? 3 : r], a) * coord_q[a][s]);
          end
        end
        bias_q[r] <= CLIP_W'(lane_coef(matrix_i[(r == 2) ? 3 : r], 3)) <<< 8;
      end
      for (int i = 0; i < CORNER_COUNT; i++) begin
        for (int r = 0; r < ROWS; r++) begin
          clip_q[i][r] <= CLIP_W'(prod_q[r][0][i & 1]) + CLIP_W'(prod_q[r][1][(i >> 1) & 1])
                        + CLIP_W'(prod_q[r][2][(i >> 2) & 1]) + bias_q[r];
        end
      end
      wz_o <= wz_d;
      for (int i = 0; i < CORNER_COUNT; i++) begin
        num_o[i][0] <= {clip_abs(clip_q[i][0]), 16'b0};
        num_o[i][1] <= {clip_abs(clip_q[i][1]), 16'b0};
        den_o[i]    <= clip_abs(clip_q[i][2]);
        neg_o[i][0] <= clip_q[i][0][CLIP_W-1] ^ clip_q[i][2][CLIP_W-1];
        neg_o[i][1] <= clip_q[i][1][CLIP_W-1] ^ clip_q[i][2][CLIP_W-1];
      end
    end
  end

endmodule

// File: sv/sslod_div.sv
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
`timescale 1ns / 1ps
module sslod_div
  import sslod_pkg::*;
(
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [MAG_W-1:0]  num_i,
  input  logic [CLIP_W-1:0] den_i,
  input  logic              neg_i,
  output logic [MAG_W-1:0]  quo_o,
  output logic              neg_o
);

  logic [REM_W-1:0]  rem_q [MAG_W];
  logic [MAG_W-1:0]  num_q [MAG_W];
  logic [MAG_W-1:0]  quo_q [MAG_W];
  logic [CLIP_W-1:0] den_q [MAG_W];
  logic              neg_q [MAG_W];

  for (genvar k = 0; k < MAG_W; k++) begin : g_stage
    logic [REM_W-1:0]  rem_s;
    logic [MAG_W-1:0]  num_s;
    logic [MAG_W-1:0]  quo_s;
    logic [CLIP_W-1:0] den_s;
    logic              neg_s;
    logic [REM_W-1:0]  trial;

    if (k == 0) begin : g_first
      assign rem_s = '0;
      assign num_s = num_i;
      assign quo_s = '0;
      assign den_s = den_i;
      assign neg_s = neg_i;
    end else begin : g_next
      assign rem_s = rem_q[k-1];
      assign num_s = num_q[k-1];
      assign quo_s = quo_q[k-1];
      assign den_s = den_q[k-1];
      assign neg_s = neg_q[k-1];
    end

    assign trial = {rem_s[REM_W-2:0], num_s[MAG_W-1]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (trial >= REM_W'(den_s)) begin
          rem_q[k] <= trial - REM_W'(den_s);
          quo_q[k] <= {quo_s[MAG_W-2:0], 1'b1};
        end else begin
          rem_q[k] <= trial;
          quo_q[k] <= {quo_s[MAG_W-2:0], 1'b0};
        end
        num_q[k] <= num_s << 1;
        den_q[k] <= den_s;
        neg_q[k] <= neg_s;
      end
    end
  end

  assign quo_o = quo_q[MAG_W-1];
  assign neg_o = neg_q[MAG_W-1];

endmodule

// File: sv/sslod_bbox.sv
// Bounding box of the projected corners, pixel scaling and level choice.
`timescale 1ns / 1ps
module sslod_bbox
  import sslod_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic              wz_i,
  input  logic [MAG_W-1:0]  quo_i [CORNER_COUNT][2],
  input  logic              neg_i [CORNER_COUNT][2],
  input  logic [SCR_W-1:0]  scr_w_i,
  input  logic [SCR_W-1:0]  scr_h_i,
  output logic              valid_o,
  output logic [1:0]        detail_o,
  output logic [OUT_W-1:0]  pixel_o,
  output logic              wz_o
);

  logic signed [NDC_W-1:0] ndc_q [CORNER_COUNT][2];
  logic signed [NDC_W-1:0] l1_min_q [4][2];
  logic signed [NDC_W-1:0] l1_max_q [4][2];
  logic signed [NDC_W-1:0] l2_min_q [2][2];
  logic signed [NDC_W-1:0] l2_max_q [2][2];
  logic signed [NDC_W-1:0] l3_min_q [2];
  logic signed [NDC_W-1:0] l3_max_q [2];
  logic [SPAN_W-1:0] span_q [2];
  logic [PIX_W-1:0]  scaled_q [2];
  logic [5:0] vld_q;
  logic [5:0] wz_q;

  logic [NDC_W-1:0] diff [2];
  logic [PIX_W-1:0] big;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      vld_q   <= {vld_q[4:0], valid_i};
      valid_o <= vld_q[5];
    end
  end

  always_comb begin
    for (int ax = 0; ax < 2; ax++) begin
      diff[ax] = NDC_W'(l3_max_q[ax] - l3_min_q[ax]);
    end
    big = (scaled_q[0] > scaled_q[1]) ? scaled_q[0] : scaled_q[1];
  end

  // A corner with zero w forces the result, so its quotient is never masked.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wz_q <= {wz_q[4:0], wz_i};
      for (int i = 0; i < CORNER_COUNT; i++) begin
        for (int ax = 0; ax < 2; ax++) begin
          ndc_q[i][ax] <= neg_i[i][ax] ? -$signed({1'b0, quo_i[i][ax]})
                                       : $signed({1'b0, quo_i[i][ax]});
        end
      end
      for (int ax = 0; ax < 2; ax++) begin
        for (int j = 0; j < 4; j++) begin
          l1_min_q[j][ax] <= (ndc_q[2*j][ax] < ndc_q[2*j+1][ax]) ? ndc_q[2*j][ax]
                                                                  : ndc_q[2*j+1][ax];
          l1_max_q[j][ax] <= (ndc_q[2*j][ax] > ndc_q[2*j+1][ax]) ? ndc_q[2*j][ax]
                                                                  : ndc_q[2*j+1][ax];
        end
        for (int j = 0; j < 2; j++) begin
          l2_min_q[j][ax] <= (l1_min_q[2*j][ax] < l1_min_q[2*j+1][ax]) ? l1_min_q[2*j][ax]
                                                                        : l1_min_q[2*j+1][ax];
          l2_max_q[j][ax] <= (l1_max_q[2*j][ax] > l1_max_q[2*j+1][ax]) ? l1_max_q[2*j][ax]
                                                                        : l1_max_q[2*j+1][ax];
        end
        l3_min_q[ax] <= (l2_min_q[0][ax] < l2_min_q[1][ax]) ? l2_min_q[0][ax] : l2_min_q[1][ax];
        l3_max_q[ax] <= (l2_max_q[0][ax] > l2_max_q[1][ax]) ? l2_max_q[0][ax] : l2_max_q[1][ax];
        span_q[ax]   <= (diff[ax] > NDC_W'(SPAN_CAP)) ? SPAN_CAP : SPAN_W'(diff[ax]);
      end
      scaled_q[0] <= PIX_W'(span_q[0] * scr_w_i);
      scaled_q[1] <= PIX_W'(span_q[1] * scr_h_i);
      wz_o <= wz_q[5];
      if (wz_q[5]) begin
        detail_o <= LOD_FULL;
        pixel_o  <= PIX_MAX;
      end else begin
        if (big > LOD0_LIMIT) detail_o <= LOD_FULL;
        else if (big > LOD1_LIMIT) detail_o <= LOD_MEDIUM;
        else detail_o <= LOD_LOW;
        pixel_o <= ((big >> 17) > PIX_W'(PIX_MAX)) ? PIX_MAX : OUT_W'(big >> 17);
      end
    end
  end

endmodule

// File: sv/screen_space_lod_select_unit.sv
// Top level of the screen-space LOD select unit: register port and pipeline.
//
// One cube center enters on the input channel (center_x_i, center_y_i,
// center_z_i with in_valid_i / in_stall_o); one result leaves on the output
// channel (detail_level_o, pixel_extent_o, w_zero_seen_o with out_valid_o /
// out_stall_i). A transaction completes when valid is high and stall is low.
// The pipeline takes one center every cycle while the output is not stalled.
// Each center passes through corner forming and the clip transform, the
// per-corner divider (one quotient bit per stage) and box, scaling and level.
// Sixteen dividers run side by side, one per corner and screen axis.
// When the output holds a result and the receiver stalls, the whole pipeline
// freezes and in_stall_o is raised; nothing is dropped or repeated.
// Reset empties the pipeline and loads the identity matrix, a 1920 by 1080
// screen and a half extent of 8.0. Registers are written through the APB
// port at byte address 8 * index and are read back there; they should be
// changed only while no transaction is in flight.
`timescale 1ns / 1ps
module screen_space_lod_select_unit
  import sslod_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [IN_W-1:0] center_x_i,
  input  logic signed [IN_W-1:0] center_y_i,
  input  logic signed [IN_W-1:0] center_z_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             detail_level_o,
  output logic [OUT_W-1:0]       pixel_extent_o,
  output logic                   w_zero_seen_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [ROW_W-1:0]       pwdata,
  output logic [ROW_W-1:0]       prdata,
  output logic                   pready
);

  logic [ROW_W-1:0]  matrix_q [4];
  logic [SCR_W-1:0]  scr_w_q;
  logic [SCR_W-1:0]  scr_h_q;
  logic [HALF_W-1:0] half_q;
  cfg_reg_e          reg_sel;
  logic              en;

  logic              c_valid;
  logic              c_wz;
  logic [MAG_W-1:0]  c_num [CORNER_COUNT][2];
  logic [CLIP_W-1:0] c_den [CORNER_COUNT];
  logic              c_neg [CORNER_COUNT][2];
  logic [MAG_W-1:0]  d_quo [CORNER_COUNT][2];
  logic              d_neg [CORNER_COUNT][2];
  logic [MAG_W-1:0]  dly_valid_q;
  logic [MAG_W-1:0]  dly_wz_q;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matrix_q[0] <= ROW_W'(64'd4096);
      matrix_q[1] <= ROW_W'(64'd268435456);
      matrix_q[2] <= ROW_W'(64'd17592186044416);
      matrix_q[3] <= ROW_W'(64'd1152921504606846976);
      scr_w_q     <= SCR_W'(1920);
      scr_h_q     <= SCR_W'(1080);
      half_q      <= HALF_W'(2048);
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_ROW0:   matrix_q[0] <= pwdata;
        REG_ROW1:   matrix_q[1] <= pwdata;
        REG_ROW2:   matrix_q[2] <= pwdata;
        REG_ROW3:   matrix_q[3] <= pwdata;
        REG_WIDTH:  scr_w_q     <= pwdata[SCR_W-1:0];
        REG_HEIGHT: scr_h_q     <= pwdata[SCR_W-1:0];
        REG_HALF:   half_q      <= pwdata[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ROW0:   prdata = matrix_q[0];
      REG_ROW1:   prdata = matrix_q[1];
      REG_ROW2:   prdata = matrix_q[2];
      REG_ROW3:   prdata = matrix_q[3];
      REG_WIDTH:  prdata = ROW_W'(scr_w_q);
      REG_HEIGHT: prdata = ROW_W'(scr_h_q);
      REG_HALF:   prdata = ROW_W'(half_q);
      default:    prdata = '0;
    endcase
  end

  // The pipeline advances as one; it holds only while a result waits.
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  sslod_corner u_corner (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (in_valid_i),
    .center_x_i (center_x_i),
    .center_y_i (center_y_i),
    .center_z_i (center_z_i),
    .matrix_i   (matrix_q),
    .half_i     (half_q),
    .valid_o    (c_valid),
    .wz_o       (c_wz),
    .num_o      (c_num),
    .den_o      (c_den),
    .neg_o      (c_neg)
  );

  for (genvar i = 0; i < CORNER_COUNT; i++) begin : g_corner
    for (genvar ax = 0; ax < 2; ax++) begin : g_axis
      sslod_div u_div (
        .clk_i (clk_i),
        .en_i  (en),
        .num_i (c_num[i][ax]),
        .den_i (c_den[i]),
        .neg_i (c_neg[i][ax]),
        .quo_o (d_quo[i][ax]),
        .neg_o (d_neg[i][ax])
      );
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dly_valid_q <= '0;
    end else if (en) begin
      dly_valid_q <= {dly_valid_q[MAG_W-2:0], c_valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dly_wz_q <= {dly_wz_q[MAG_W-2:0], c_wz};
    end
  end

  sslod_bbox u_bbox (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (dly_valid_q[MAG_W-1]),
    .wz_i     (dly_wz_q[MAG_W-1]),
    .quo_i    (d_quo),
    .neg_i    (d_neg),
    .scr_w_i  (scr_w_q),
    .scr_h_i  (scr_h_q),
    .valid_o  (out_valid_o),
    .detail_o (detail_level_o),
    .pixel_o  (pixel_extent_o),
    .wz_o     (w_zero_seen_o)
  );

endmodule
